FILE: rtl/pce_pkg.sv
// Package for the Pearson correlation engine: word types, sizes, sequencer codes.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package pce_pkg;

  localparam int unsigned MAX_PAIRS_DEF   = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned RESULT_FRAC_DEF = 30;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CORR_W   = 32;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned SQ_W     = 48;
  localparam int unsigned VAR_W    = 64;
  localparam int unsigned MUL_W    = 33;
  localparam int unsigned PROD_W   = 66;
  localparam int unsigned ACC_W    = 128;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     degenerate;
    logic [COUNT_W-1:0]       pair_count;
    logic                     overflowed;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_FIN, ST_WAIT, ST_LAUNCH, ST_SRCH, ST_RES
  } state_e;

  // multiplier micro-ops, issued in this order
  typedef enum logic [4:0] {
    U_NONE, U_XY, U_XX, U_YY,
    U_NUM0, U_NUM1, U_NUM2,
    U_VA0, U_VA1, U_VA2,
    U_VB0, U_VB1, U_VB2,
    U_M0, U_M1, U_M2, U_M3,
    U_P0, U_P1, U_P2, U_P3
  } uop_e;

endpackage

`default_nettype wire

FILE: rtl/pce_mul.sv
// Shared signed 33x33 multiplier with registered product.
// Depends on pce_pkg.
`default_nettype none

module pce_mul import pce_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic signed [MUL_W-1:0]  a_i,
  input  wire logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]      p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/pce_search.sv
// Bit-serial search for the largest q with q^2 * P <= M * 2^(2F).
// Shift-and-add only; depends on pce_pkg.
`default_nettype none

module pce_search import pce_pkg::*; #(
  parameter int unsigned FRAC_BITS = RESULT_FRAC_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [ACC_W-1:0]     p_i,
  input  wire logic [ACC_W-1:0]     m_i,
  output logic                      done_o,
  output logic [FRAC_BITS:0]        q_o
);

  localparam int unsigned W  = ACC_W + 2 * FRAC_BITS + 4;
  localparam int unsigned CW = $clog2(FRAC_BITS + 2);

  logic          busy_q, phase_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  s_q, a_q, b_q, t_q, m2_q;
  logic [FRAC_BITS:0] q_q;

  logic [W-1:0] trial, a_upd;
  logic         ok;

  // a holds q*P scaled by 2^(k+1), b holds P scaled by 2^(2k)
  assign trial = t_q + b_q;
  assign ok    = trial <= m2_q;
  assign a_upd = ok ? a_q + (b_q << 1) : a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= CW'(FRAC_BITS + 1);
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q  <= '0;
      a_q  <= '0;
      t_q  <= '0;
      q_q  <= '0;
      b_q  <= W'(p_i) << (2 * FRAC_BITS);
      m2_q <= W'(m_i) << (2 * FRAC_BITS);
    end else if (busy_q) begin
      if (!phase_q) begin
        t_q <= s_q + a_q;
      end else begin
        if (ok) begin
          s_q <= trial;
        end
        a_q <= a_upd >> 1;
        b_q <= b_q >> 2;
        q_q <= {q_q[FRAC_BITS-1:0], ok};
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = (q_q[FRAC_BITS] && (|q_q[FRAC_BITS-1:0]))
                  ? {1'b1, {FRAC_BITS{1'b0}}} : q_q;

endmodule

`default_nettype wire

FILE: rtl/pearson_correlation_engine.sv
// Pearson correlation engine top level: sequencer, running sums, output register.
// Depends on pce_pkg, pce_mul and pce_search.
//
// Usage: sample pairs enter on the in channel (valid/ready), one word per pair.
// Each accepted pair within MAX_PAIRS is latched, then its three products
// (xy, x^2, y^2) through the single shared multiplier; ready is low meanwhile.
// On a word with last_sample set, the engine forms the numerator and both
// variance terms, their products and the squared numerator in 17 multiplier
// passes, then runs a bit-serial search for RESULT_FRACTION_BITS+1 result bits.
// A degenerate set (a zero variance term) skips the search.
// One result word per set appears on the out channel.
// The result sits in an output register: new pairs are accepted while it
// waits, and only the next set's final result waits for out_ready_i.
// Pairs beyond MAX_PAIRS are dropped and flagged. Reset (rst_ni low, async)
// clears all sums, the count and the output valid.
`default_nettype none

module pearson_correlation_engine import pce_pkg::*; #(
  parameter int unsigned MAX_PAIRS            = MAX_PAIRS_DEF,
  parameter int unsigned SAMPLE_BITS          = SAMPLE_BITS_DEF,
  parameter int unsigned RESULT_FRACTION_BITS = RESULT_FRAC_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  localparam int unsigned F = RESULT_FRACTION_BITS;

  state_e state_q, state_d;
  uop_e   uop_q, uop_d, pend_q, pend_d;

  logic [COUNT_W-1:0] n_q, n_d;
  logic               ovf_q, ovf_d;
  logic [SUM_W-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [SQ_W-1:0]    sxy_q, sxy_d, sxx_q, sxx_d, syy_q, syy_d;

  logic [SAMPLE_BITS-1:0] x_q, x_d, y_q, y_d;
  logic                   last_q, last_d;
  logic [ACC_W-1:0]       acc_q, acc_d, m_q, m_d, p_q, p_d;
  logic [VAR_W-1:0]       num_q, num_d, va_q, va_d, vb_q, vb_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         pe;

  logic [MUL_W-1:0] xe, ye, n33, sx33, sy33, mag_lo, mag_hi;
  logic [VAR_W-1:0] mag;
  logic             accept, degen, srch_start, srch_done;
  logic [F:0]       qs;
  logic [CORR_W-1:0] corr_mag;

  assign xe     = {{(MUL_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
  assign ye     = {{(MUL_W-SAMPLE_BITS){y_q[SAMPLE_BITS-1]}}, y_q};
  assign n33    = {{(MUL_W-COUNT_W){1'b0}}, n_q};
  assign sx33   = {sx_q[SUM_W-1], sx_q};
  assign sy33   = {sy_q[SUM_W-1], sy_q};
  assign mag    = num_q[VAR_W-1] ? (~num_q + 1'b1) : num_q;
  assign mag_lo = {1'b0, mag[31:0]};
  assign mag_hi = {1'b0, mag[63:32]};
  assign pe     = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign degen  = (va_q == '0) || (vb_q == '0);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign srch_start = (state_q == ST_LAUNCH);
  assign corr_mag   = {{(CORR_W-F-1){1'b0}}, qs};

  // operand select for the issued micro-op
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if ((state_q == ST_MAC) || (state_q == ST_FIN)) begin
      unique case (uop_q)
        U_XY:   begin mul_a = xe;  mul_b = ye; end
        U_XX:   begin mul_a = xe;  mul_b = xe; end
        U_YY:   begin mul_a = ye;  mul_b = ye; end
        U_NUM0: begin mul_a = n33; mul_b = {1'b0, sxy_q[31:0]}; end
        U_NUM1: begin mul_a = n33; mul_b = {{(MUL_W-16){sxy_q[47]}}, sxy_q[47:32]}; end
        U_NUM2: begin mul_a = sx33; mul_b = sy33; end
        U_VA0:  begin mul_a = n33; mul_b = {1'b0, sxx_q[31:0]}; end
        U_VA1:  begin mul_a = n33; mul_b = {{(MUL_W-16){sxx_q[47]}}, sxx_q[47:32]}; end
        U_VA2:  begin mul_a = sx33; mul_b = sx33; end
        U_VB0:  begin mul_a = n33; mul_b = {1'b0, syy_q[31:0]}; end
        U_VB1:  begin mul_a = n33; mul_b = {{(MUL_W-16){syy_q[47]}}, syy_q[47:32]}; end
        U_VB2:  begin mul_a = sy33; mul_b = sy33; end
        U_M0:   begin mul_a = mag_lo; mul_b = mag_lo; end
        U_M1:   begin mul_a = mag_lo; mul_b = mag_hi; end
        U_M2:   begin mul_a = mag_hi; mul_b = mag_lo; end
        U_M3:   begin mul_a = mag_hi; mul_b = mag_hi; end
        U_P0:   begin mul_a = {1'b0, va_q[31:0]};  mul_b = {1'b0, vb_q[31:0]}; end
        U_P1:   begin mul_a = {1'b0, va_q[31:0]};  mul_b = {1'b0, vb_q[63:32]}; end
        U_P2:   begin mul_a = {1'b0, va_q[63:32]}; mul_b = {1'b0, vb_q[31:0]}; end
        U_P3:   begin mul_a = {1'b0, va_q[63:32]}; mul_b = {1'b0, vb_q[63:32]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  pce_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pce_search #(
    .FRAC_BITS (F)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .p_i     (p_q),
    .m_i     (m_q),
    .done_o  (srch_done),
    .q_o     (qs)
  );

  always_comb begin
    state_d     = state_q;
    uop_d       = uop_q;
    pend_d      = U_NONE;
    n_d         = n_q;
    ovf_d       = ovf_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxy_d       = sxy_q;
    sxx_d       = sxx_q;
    syy_d       = syy_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;
    acc_d       = acc_q;
    num_d       = num_q;
    va_d        = va_q;
    vb_d        = vb_q;
    m_d         = m_q;
    p_d         = p_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if ((state_q == ST_MAC) || (state_q == ST_FIN)) begin
      pend_d = uop_q;
    end

    // retire the product issued last cycle
    unique case (pend_q)
      U_XY: sxy_d = sxy_q + prod[SQ_W-1:0];
      U_XX: sxx_d = sxx_q + prod[SQ_W-1:0];
      U_YY: syy_d = syy_q + prod[SQ_W-1:0];
      U_NUM0, U_VA0, U_VB0, U_M0, U_P0: acc_d = pe;
      U_NUM1, U_VA1, U_VB1, U_M1, U_M2, U_P1, U_P2: acc_d = acc_q + (pe << 32);
      U_NUM2: begin acc_d = acc_q - pe; num_d = acc_d[VAR_W-1:0]; end
      U_VA2:  begin acc_d = acc_q - pe; va_d  = acc_d[VAR_W-1:0]; end
      U_VB2:  begin acc_d = acc_q - pe; vb_d  = acc_d[VAR_W-1:0]; end
      U_M3:   begin acc_d = acc_q + (pe << 64); m_d = acc_d; end
      U_P3:   begin acc_d = acc_q + (pe << 64); p_d = acc_d; end
      default: ;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d    = in_data_i.x_sample[SAMPLE_BITS-1:0];
          y_d    = in_data_i.y_sample[SAMPLE_BITS-1:0];
          last_d = in_data_i.last_sample;
          if (n_q == COUNT_W'(MAX_PAIRS)) begin
            ovf_d = 1'b1;
            uop_d = U_NUM0;
            state_d = in_data_i.last_sample ? ST_FIN : ST_IDLE;
          end else begin
            n_d  = n_q + 1'b1;
            sx_d = sx_q + {{(SUM_W-SAMPLE_BITS){x_d[SAMPLE_BITS-1]}}, x_d};
            sy_d = sy_q + {{(SUM_W-SAMPLE_BITS){y_d[SAMPLE_BITS-1]}}, y_d};
            uop_d   = U_XY;
            state_d = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        uop_d = uop_e'(uop_q + 5'd1);
        if (uop_q == U_YY) begin
          if (last_q) begin
            uop_d   = U_NUM0;
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        uop_d = uop_e'(uop_q + 5'd1);
        if (uop_q == U_P3) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = degen ? ST_RES : ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_d = ST_SRCH;
      end
      ST_SRCH: begin
        if (srch_done) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.degenerate      = degen;
          out_d.pair_count      = n_q;
          out_d.overflowed      = ovf_q;
          if (degen) begin
            out_d.correlation = '0;
          end else if (num_q[VAR_W-1]) begin
            out_d.correlation = ~corr_mag + 1'b1;
          end else begin
            out_d.correlation = corr_mag;
          end
          n_d     = '0;
          ovf_d   = 1'b0;
          sx_d    = '0;
          sy_d    = '0;
          sxy_d   = '0;
          sxx_d   = '0;
          syy_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      uop_q       <= U_NONE;
      pend_q      <= U_NONE;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      uop_q       <= uop_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      ovf_q       <= ovf_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sxy_q       <= sxy_d;
      sxx_q       <= sxx_d;
      syy_q       <= syy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    last_q <= last_d;
    acc_q  <= acc_d;
    num_q  <= num_d;
    va_q   <= va_d;
    vb_q   <= vb_d;
    m_q    <= m_d;
    p_q    <= p_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
